### hdl/cfr_pkg.sv
package cfr_pkg;

	localparam logic [7:0] HDR_BYTE  = 8'hFE;
	localparam logic [7:0] TAIL_BYTE = 8'hBB;

	localparam logic [7:0] EXPECTED_COMMAND_RST = 8'd97;
	localparam logic [7:0] EXPECTED_LENGTH_RST  = 8'd28;

	localparam logic CFG_EXPECTED_COMMAND = 1'b0;
	localparam logic CFG_EXPECTED_LENGTH  = 1'b1;

	typedef enum logic [2:0] {
		ST_HEAD1   = 3'd0,
		ST_HEAD2   = 3'd1,
		ST_CMD     = 3'd2,
		ST_LEN     = 3'd3,
		ST_PAYLOAD = 3'd4,
		ST_CRCHI   = 3'd5,
		ST_CRCLO   = 3'd6,
		ST_TAIL    = 3'd7
	} stage_t;

	typedef enum logic [1:0] {
		EV_NONE    = 2'd0,
		EV_PAYLOAD = 2'd1,
		EV_ACCEPT  = 2'd2,
		EV_REJECT  = 2'd3
	} event_t;

	// CRC-16/XMODEM (poly 0x1021), one byte per call
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = {crc[7:0], crc[15:8]};
		c = c ^ {8'h00, b};
		c = c ^ {12'h000, c[7:4]};
		c = c ^ {c[3:0], 12'h000};
		c = c ^ {3'b000, c[7:0], 5'b00000};
		return c;
	endfunction

endpackage

### hdl/crc_checked_frame_receiver_core.sv
// Serial frame receiver: hunts for FE FE <command> <length>, forwards each payload byte
// with its index, then checks the big-endian CRC-16/XMODEM (over command, length and
// payload) and the 0xBB tail, giving one accept or reject event per frame. Every byte
// accepted on the input gives exactly one result transfer (event 0 when there is nothing
// to report). One byte is taken every cycle unless the input stalls; the byte passes
// through the input register, where the frame state and the one-byte CRC update are
// evaluated combinationally, and its result is held in the result register until it
// transfers. The block takes a new byte while a result waits to be taken and stalls
// only when both registers are full and the result is held off. The user must write
// configuration only while no byte is in flight; the block itself does not enforce this.
module crc_checked_frame_receiver_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  event_res,
	output logic [7:0]  payload_byte,
	output logic [7:0]  payload_index
);

	logic [7:0] exp_cmd_q;
	logic [7:0] exp_len_q;

	logic       valid_s1;
	logic [7:0] rx_s1;

	cfr_pkg::stage_t stage_q, stage_d;
	logic [7:0]  count_q, count_d;
	logic [15:0] crc_q, crc_d;
	logic [15:0] rcrc_q, rcrc_d;
	logic [7:0]  fcmd_q, fcmd_d;
	logic [7:0]  flen_q, flen_d;

	logic        out_valid_q;
	cfr_pkg::event_t ev_q, ev_d;
	logic [7:0]  pb_q, pb_d;
	logic [7:0]  pi_q, pi_d;

	logic        advance;
	logic [7:0]  count_inc;

	assign advance   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && out_valid_q && out_stall;
	assign count_inc = count_q + 8'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_cmd_q <= cfr_pkg::EXPECTED_COMMAND_RST;
			exp_len_q <= cfr_pkg::EXPECTED_LENGTH_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				cfr_pkg::CFG_EXPECTED_COMMAND: exp_cmd_q <= cfg_data;
				cfr_pkg::CFG_EXPECTED_LENGTH:  exp_len_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			rx_s1 <= rx_byte;
		end
	end

	always_comb begin
		stage_d = stage_q;
		count_d = count_q;
		crc_d   = crc_q;
		rcrc_d  = rcrc_q;
		fcmd_d  = fcmd_q;
		flen_d  = flen_q;
		ev_d    = cfr_pkg::EV_NONE;
		pb_d    = 8'h00;
		pi_d    = 8'h00;
		case (stage_q)
			cfr_pkg::ST_HEAD1: begin
				if (rx_s1 == cfr_pkg::HDR_BYTE) stage_d = cfr_pkg::ST_HEAD2;
			end
			cfr_pkg::ST_HEAD2: begin
				stage_d = (rx_s1 == cfr_pkg::HDR_BYTE) ? cfr_pkg::ST_CMD : cfr_pkg::ST_HEAD1;
			end
			cfr_pkg::ST_CMD: begin
				if (rx_s1 == exp_cmd_q) begin
					fcmd_d  = rx_s1;
					crc_d   = cfr_pkg::crc_byte(16'h0000, rx_s1);
					stage_d = cfr_pkg::ST_LEN;
				end else if (rx_s1 != cfr_pkg::HDR_BYTE) begin
					stage_d = cfr_pkg::ST_HEAD1;
				end
			end
			cfr_pkg::ST_LEN: begin
				if (rx_s1 != exp_len_q) begin
					// a mismatching FE may open the next header
					stage_d = (rx_s1 == cfr_pkg::HDR_BYTE) ? cfr_pkg::ST_HEAD2
					                                        : cfr_pkg::ST_HEAD1;
				end else begin
					flen_d  = rx_s1;
					crc_d   = cfr_pkg::crc_byte(crc_q, rx_s1);
					count_d = 8'h00;
					stage_d = (rx_s1 == 8'h00) ? cfr_pkg::ST_CRCHI : cfr_pkg::ST_PAYLOAD;
				end
			end
			cfr_pkg::ST_PAYLOAD: begin
				ev_d    = cfr_pkg::EV_PAYLOAD;
				pb_d    = rx_s1;
				pi_d    = count_q;
				crc_d   = cfr_pkg::crc_byte(crc_q, rx_s1);
				count_d = count_inc;
				if (count_inc >= flen_q) stage_d = cfr_pkg::ST_CRCHI;
			end
			cfr_pkg::ST_CRCHI: begin
				rcrc_d  = {rx_s1, 8'h00};
				stage_d = cfr_pkg::ST_CRCLO;
			end
			cfr_pkg::ST_CRCLO: begin
				rcrc_d  = {rcrc_q[15:8], rx_s1};
				stage_d = cfr_pkg::ST_TAIL;
			end
			cfr_pkg::ST_TAIL: begin
				if (rx_s1 == cfr_pkg::TAIL_BYTE && fcmd_q == exp_cmd_q &&
				    flen_q == exp_len_q && crc_q == rcrc_q) begin
					ev_d    = cfr_pkg::EV_ACCEPT;
					stage_d = cfr_pkg::ST_HEAD1;
				end else begin
					ev_d    = cfr_pkg::EV_REJECT;
					stage_d = (rx_s1 == cfr_pkg::HDR_BYTE) ? cfr_pkg::ST_HEAD2
					                                        : cfr_pkg::ST_HEAD1;
				end
			end
			default: stage_d = cfr_pkg::ST_HEAD1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q <= cfr_pkg::ST_HEAD1;
			count_q <= 8'h00;
			crc_q   <= 16'h0000;
			rcrc_q  <= 16'h0000;
			fcmd_q  <= 8'h00;
			flen_q  <= 8'h00;
		end else if (advance) begin
			stage_q <= stage_d;
			count_q <= count_d;
			crc_q   <= crc_d;
			rcrc_q  <= rcrc_d;
			fcmd_q  <= fcmd_d;
			flen_q  <= flen_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			ev_q <= ev_d;
			pb_q <= pb_d;
			pi_q <= pi_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign event_res     = ev_q;
	assign payload_byte  = pb_q;
	assign payload_index = pi_q;

`ifndef SYNTH
	a_payload_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && ev_q != cfr_pkg::EV_PAYLOAD) |-> (pb_q == 8'h00 && pi_q == 8'h00))
		else $error("payload fields nonzero outside a payload event");

	a_count_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(stage_q == cfr_pkg::ST_PAYLOAD) |-> (count_q < flen_q))
		else $error("payload count reached frame length inside payload phase");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q))
		else $error("input stalled with a free register");

	a_accept_after_tail: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && (ev_d == cfr_pkg::EV_ACCEPT || ev_d == cfr_pkg::EV_REJECT))
		|-> (stage_q == cfr_pkg::ST_TAIL))
		else $error("verdict outside tail stage");
`endif

endmodule

### bench/crc_checked_frame_receiver_core_checker.sv
package cfr_tb_pkg;

	// bitwise CRC-16/XMODEM, MSB first
	function automatic logic [15:0] xmodem_update(input logic [15:0] crc, input logic [7:0] d);
		logic [15:0] c;
		c = crc ^ {d, 8'h00};
		for (int k = 0; k < 8; k++)
			c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
		return c;
	endfunction

endpackage

module crc_checked_frame_receiver_core_checker
	import cfr_pkg::*;
	import cfr_tb_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [7:0] cfg_data,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic [7:0] rx_byte,
	input  logic       out_valid,
	input  logic       out_stall,
	input  logic [1:0] event_res,
	input  logic [7:0] payload_byte,
	input  logic [7:0] payload_index,
	output int         mismatches,
	output int         results_owed
);

	typedef struct packed {
		event_t     ev;
		logic [7:0] data;
		logic [7:0] index;
	} frame_event_t;

	frame_event_t owed_q[$];

	stage_t      stage;
	logic [7:0]  want_cmd, want_len;
	logic [7:0]  got_cmd, got_len;
	logic [7:0]  taken;
	logic [15:0] crc_acc, crc_rx;

	// advance the parser by one byte and return the event it gives
	function automatic frame_event_t parse_byte(input logic [7:0] b);
		frame_event_t r;
		r = '{EV_NONE, 8'h00, 8'h00};
		case (stage)
			ST_HEAD1: begin
				if (b == HDR_BYTE)
					stage = ST_HEAD2;
			end
			ST_HEAD2: begin
				stage = (b == HDR_BYTE) ? ST_CMD : ST_HEAD1;
			end
			ST_CMD: begin
				if (b == want_cmd) begin
					got_cmd = b;
					crc_acc = xmodem_update(16'h0000, b);
					stage = ST_LEN;
				end else if (b != HDR_BYTE) begin
					stage = ST_HEAD1;
				end
			end
			ST_LEN: begin
				if (b != want_len) begin
					// a header byte here restarts the hunt one byte in
					stage = (b == HDR_BYTE) ? ST_HEAD2 : ST_HEAD1;
				end else begin
					got_len = b;
					crc_acc = xmodem_update(crc_acc, b);
					taken = 8'd0;
					stage = (b == 8'd0) ? ST_CRCHI : ST_PAYLOAD;
				end
			end
			ST_PAYLOAD: begin
				r = '{EV_PAYLOAD, b, taken};
				crc_acc = xmodem_update(crc_acc, b);
				taken = taken + 8'd1;
				if (taken >= got_len)
					stage = ST_CRCHI;
			end
			ST_CRCHI: begin
				crc_rx = {b, 8'h00};
				stage = ST_CRCLO;
			end
			ST_CRCLO: begin
				crc_rx[7:0] = b;
				stage = ST_TAIL;
			end
			default: begin
				if (b == TAIL_BYTE && got_cmd == want_cmd && got_len == want_len
						&& crc_acc == crc_rx) begin
					r.ev = EV_ACCEPT;
					stage = ST_HEAD1;
				end else begin
					r.ev = EV_REJECT;
					stage = (b == HDR_BYTE) ? ST_HEAD2 : ST_HEAD1;
				end
			end
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		frame_event_t want;
		if (!arst_n) begin
			stage = ST_HEAD1;
			want_cmd = EXPECTED_COMMAND_RST;
			want_len = EXPECTED_LENGTH_RST;
			got_cmd = 8'd0;
			got_len = 8'd0;
			taken = 8'd0;
			crc_acc = 16'd0;
			crc_rx = 16'd0;
			owed_q.delete();
			mismatches = 0;
			results_owed = 0;
		end else begin
			// compare first, so a spurious result never meets this cycle's expectation
			if (out_valid && !out_stall) begin
				if (owed_q.size() == 0) begin
					$error("result transfer with none expected: event_res %0d", event_res);
					mismatches++;
				end else begin
					want = owed_q.pop_front();
					if (event_res !== want.ev) begin
						$error("event_res: expected %0d, got %0d", want.ev, event_res);
						mismatches++;
					end
					if (payload_byte !== want.data) begin
						$error("payload_byte: expected %0h, got %0h", want.data, payload_byte);
						mismatches++;
					end
					if (payload_index !== want.index) begin
						$error("payload_index: expected %0d, got %0d", want.index, payload_index);
						mismatches++;
					end
				end
			end
			if (cfg_we) begin
				if (cfg_index == CFG_EXPECTED_COMMAND)
					want_cmd = cfg_data;
				else
					want_len = cfg_data;
			end
			if (in_valid && !in_stall)
				owed_q = {owed_q, parse_byte(rx_byte)};
			results_owed = owed_q.size();
		end
	end

endmodule

### bench/crc_checked_frame_receiver_core_tb.sv
module crc_checked_frame_receiver_core_tb;
	import cfr_pkg::*;
	import cfr_tb_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int PHASE_BYTES = 130;
	localparam int LONG_PHASE_BYTES = 500;
	localparam int HOLD_CYCLES = 80;

	typedef enum int {
		FR_GOOD,
		FR_BAD_CRC,
		FR_BAD_TAIL,
		FR_BAD_LEN,
		FR_BAD_CMD,
		FR_NOISE
	} frame_kind_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	logic       cfg_index = CFG_EXPECTED_COMMAND;
	logic [7:0] cfg_data = 8'h00;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] rx_byte = 8'h00;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [1:0] event_res;
	logic [7:0] payload_byte;
	logic [7:0] payload_index;

	int mismatches;
	int results_owed;

	logic [7:0] tx_q[$];
	int         bytes_sent = 0;
	bit         steady = 1'b0;
	bit         hold_req = 1'b0;
	bit         hold_active = 1'b0;

	always #4 clk = ~clk;

	crc_checked_frame_receiver_core i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.event_res(event_res),
		.payload_byte(payload_byte),
		.payload_index(payload_index)
	);

	crc_checked_frame_receiver_core_checker i_chk (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.event_res(event_res),
		.payload_byte(payload_byte),
		.payload_index(payload_index),
		.mismatches(mismatches),
		.results_owed(results_owed)
	);

	task automatic send_byte(input logic [7:0] b);
		int r, gap;
		in_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (in_stall);
		bytes_sent++;
		r = $urandom_range(0, 99);
		if (steady || hold_active || r < 70)
			gap = 0;
		else if (r < 92)
			gap = $urandom_range(1, 3);
		else
			gap = $urandom_range(5, 30);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// queue one byte at the end of the transmit list
	task automatic append_byte(input logic [7:0] b);
		tx_q = {tx_q, b};
	endtask

	task automatic flush_tx();
		while (tx_q.size() > 0)
			send_byte(tx_q.pop_front());
	endtask

	// wait until every byte in flight has produced its result
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (results_owed != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_config(input logic [7:0] cmd, input logic [7:0] len);
		cfg_we <= 1'b1;
		cfg_index <= CFG_EXPECTED_COMMAND;
		cfg_data <= cmd;
		@(posedge clk);
		cfg_index <= CFG_EXPECTED_LENGTH;
		cfg_data <= len;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic add_frame(input logic [7:0] cmd, input logic [7:0] len,
			input frame_kind_t kind, input int lead_fe, input bit extremes);
		logic [15:0] crc;
		logic [7:0]  b;
		int          k;
		if (kind == FR_NOISE) begin
			repeat ($urandom_range(1, 6))
				append_byte(($urandom_range(0, 9) < 4) ? HDR_BYTE : 8'($urandom));
			return;
		end
		repeat (2 + lead_fe) append_byte(HDR_BYTE);
		b = cmd;
		if (kind == FR_BAD_CMD)
			while (b == cmd) b = 8'($urandom);
		append_byte(b);
		crc = xmodem_update(16'h0000, b);
		if (kind == FR_BAD_LEN) begin
			b = ($urandom_range(0, 2) == 0) ? HDR_BYTE : 8'($urandom);
			while (b == len) b = 8'($urandom);
			append_byte(b);
			return;
		end
		append_byte(len);
		crc = xmodem_update(crc, len);
		for (k = 0; k < int'(len); k++) begin
			b = extremes ? (k[0] ? 8'hFF : 8'h00) : 8'($urandom);
			append_byte(b);
			crc = xmodem_update(crc, b);
		end
		if (kind == FR_BAD_CRC)
			crc ^= 16'h0001 << $urandom_range(0, 15);
		append_byte(crc[15:8]);
		append_byte(crc[7:0]);
		b = TAIL_BYTE;
		if (kind == FR_BAD_TAIL) begin
			b = ($urandom_range(0, 2) == 0) ? HDR_BYTE : 8'($urandom);
			while (b == TAIL_BYTE) b = 8'($urandom);
		end
		append_byte(b);
	endtask

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("Regression FAIL");
		$finish;
	end

	initial begin : result_sink
		int r, n;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			r = $urandom_range(0, 99);
			if (hold_req) begin
				// back up the block until it stalls its input
				hold_req = 1'b0;
				hold_active = 1'b1;
				n = HOLD_CYCLES;
			end else if (r < 50) begin
				n = 0;
			end else if (r < 85) begin
				n = $urandom_range(1, 3);
			end else if (r < 95) begin
				n = $urandom_range(4, 12);
			end else begin
				n = $urandom_range(20, 60);
			end
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			hold_active = 1'b0;
			out_stall <= 1'b0;
			repeat ($urandom_range(1, (r < 20) ? 40 : 4)) @(posedge clk);
		end
	end

	initial begin : stimulus
		int          p, r, start;
		logic [7:0]  cmd, len;
		frame_kind_t kind;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_config(8'h61, 8'd2);
		append_byte(HDR_BYTE);
		append_byte(8'h12);
		// header bytes repeated into the command slot, payload 00 FF
		add_frame(8'h61, 8'd2, FR_GOOD, 2, 1'b1);
		// length slot holds a header byte, which restarts the hunt
		append_byte(HDR_BYTE);
		append_byte(HDR_BYTE);
		append_byte(8'h61);
		add_frame(8'h61, 8'd2, FR_GOOD, 0, 1'b0);
		// rejecting tail that is itself a header byte
		add_frame(8'h61, 8'd2, FR_GOOD, 0, 1'b0);
		tx_q[tx_q.size() - 1] = HDR_BYTE;
		add_frame(8'h61, 8'd2, FR_BAD_CRC, 0, 1'b0);
		add_frame(8'h61, 8'd2, FR_BAD_LEN, 0, 1'b0);
		flush_tx();
		drain();

		set_config(HDR_BYTE, 8'd0);
		add_frame(HDR_BYTE, 8'd0, FR_GOOD, 0, 1'b0);
		add_frame(HDR_BYTE, 8'd0, FR_GOOD, 1, 1'b0);
		flush_tx();
		drain();

		set_config(8'hFF, 8'd1);
		add_frame(8'hFF, 8'd1, FR_GOOD, 0, 1'b1);
		add_frame(8'hFF, 8'd1, FR_BAD_TAIL, 0, 1'b0);
		flush_tx();
		drain();

		for (p = 0; p < 9; p++) begin
			case (p)
				0: begin cmd = EXPECTED_COMMAND_RST; len = EXPECTED_LENGTH_RST; end
				1: begin cmd = 8'h00; len = 8'd0; end
				2: begin cmd = HDR_BYTE; len = 8'd3; end
				3: begin cmd = 8'hFF; len = 8'd1; end
				4: begin cmd = 8'h00; len = 8'd255; end
				default: begin cmd = 8'($urandom); len = 8'($urandom_range(0, 10)); end
			endcase
			set_config(cmd, len);
			if (p == 0)
				hold_req = 1'b1;
			start = bytes_sent;
			do begin
				r = $urandom_range(0, 99);
				if (r < 55)
					kind = FR_GOOD;
				else if (r < 65)
					kind = FR_BAD_CRC;
				else if (r < 75)
					kind = FR_BAD_TAIL;
				else if (r < 83)
					kind = FR_BAD_LEN;
				else if (r < 91)
					kind = FR_BAD_CMD;
				else
					kind = FR_NOISE;
				steady = ($urandom_range(0, 3) == 0);
				add_frame(cmd, len, kind,
					($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0, 1'b0);
				flush_tx();
			end while (bytes_sent - start < ((len > 8'd100) ? LONG_PHASE_BYTES : PHASE_BYTES));
			steady = 1'b0;
			drain();
		end

		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
